[rtl/core/csl_pkg.sv]
package csl_pkg;

	// Widths of the fixed fields
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int LEN_W    = 24;

	// Default sizes of the scan counters
	localparam int COUNT_BITS_DEF = 24;
	localparam int DEPTH_BITS_DEF = 8;

	// Status codes of a result
	localparam logic [STATUS_W-1:0] ST_BUSY  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IDLE  = 2'd3;

	// Characters of the syntax
	localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

endpackage

[rtl/core/csl_if.sv]
interface csl_in_if;
	logic                         valid;
	logic                         ready;
	logic [csl_pkg::BYTE_W-1:0]   data_byte;
	logic                         first;

	modport source (output valid, output data_byte, output first, input ready);
	modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface csl_out_if;
	logic                         valid;
	logic                         ready;
	logic [csl_pkg::STATUS_W-1:0] status;
	logic [csl_pkg::LEN_W-1:0]    total_length;

	modport source (output valid, output status, output total_length, input ready);
	modport sink (input valid, input status, input total_length, output ready);
endinterface

[rtl/core/canonical_sexp_length_scanner.sv]
// Canonical S-expression length scanner, one byte per request.
// Each byte passes the input register and then the result register; out_ch.ready low stalls both.
// Throughput: 1 byte per cycle if not stalled; scan state updates in one pass of byte logic.
// Reset (arst_n low, asynchronous): both stages empty, scan state cleared,
// max_length cleared to zero (no limit).
module canonical_sexp_length_scanner #(
	parameter int COUNT_BITS = csl_pkg::COUNT_BITS_DEF,
	parameter int DEPTH_BITS = csl_pkg::DEPTH_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [csl_pkg::LEN_W-1:0] cfg_wdata,
	csl_in_if.sink                    in_ch,
	csl_out_if.source                 out_ch
);

	logic                         valid_s1;
	logic [csl_pkg::BYTE_W-1:0]   data_byte_s1;
	logic                         first_s1;
	logic                         can_load;
	logic                         advance;

	logic [csl_pkg::LEN_W-1:0]    max_length_q;
	logic                         active_q;
	logic [DEPTH_BITS-1:0]        depth_q;
	logic [COUNT_BITS-1:0]        pending_q;
	logic [COUNT_BITS-1:0]        skip_q;
	logic                         hint_q;
	logic [COUNT_BITS-1:0]        count_q;

	logic                         active_nxt;
	logic [DEPTH_BITS-1:0]        depth_nxt;
	logic [COUNT_BITS-1:0]        pending_nxt;
	logic [COUNT_BITS-1:0]        skip_nxt;
	logic                         hint_nxt;
	logic [COUNT_BITS-1:0]        count_nxt;
	logic [csl_pkg::STATUS_W-1:0] status;
	logic [csl_pkg::LEN_W-1:0]    total_length;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= '0;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	// Input stage
	assign advance     = valid_s1 && can_load;
	assign in_ch.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_byte_s1 <= in_ch.data_byte;
			first_s1     <= in_ch.first;
		end
	end

	// Byte logic
	csl_scan_step #(
		.COUNT_BITS(COUNT_BITS),
		.DEPTH_BITS(DEPTH_BITS)
	) u_step (
		.data_byte     (data_byte_s1),
		.first         (first_s1),
		.max_length    (max_length_q),
		.active        (active_q),
		.depth         (depth_q),
		.pending_length(pending_q),
		.skip_left     (skip_q),
		.in_hint       (hint_q),
		.byte_count    (count_q),
		.active_nxt    (active_nxt),
		.depth_nxt     (depth_nxt),
		.pending_nxt   (pending_nxt),
		.skip_nxt      (skip_nxt),
		.hint_nxt      (hint_nxt),
		.count_nxt     (count_nxt),
		.status        (status),
		.total_length  (total_length)
	);

	// Scan state, updated as each byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			depth_q   <= '0;
			pending_q <= '0;
			skip_q    <= '0;
			hint_q    <= 1'b0;
			count_q   <= '0;
		end else if (advance) begin
			active_q  <= active_nxt;
			depth_q   <= depth_nxt;
			pending_q <= pending_nxt;
			skip_q    <= skip_nxt;
			hint_q    <= hint_nxt;
			count_q   <= count_nxt;
		end
	end

	// Result register
	csl_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (valid_s1),
		.status      (status),
		.total_length(total_length),
		.can_load    (can_load),
		.out_ch      (out_ch)
	);

endmodule

[rtl/core/csl_scan_step.sv]
module csl_scan_step #(
	parameter int COUNT_BITS = csl_pkg::COUNT_BITS_DEF,
	parameter int DEPTH_BITS = csl_pkg::DEPTH_BITS_DEF
) (
	input  logic [csl_pkg::BYTE_W-1:0]   data_byte,
	input  logic                         first,
	input  logic [csl_pkg::LEN_W-1:0]    max_length,
	input  logic                         active,
	input  logic [DEPTH_BITS-1:0]        depth,
	input  logic [COUNT_BITS-1:0]        pending_length,
	input  logic [COUNT_BITS-1:0]        skip_left,
	input  logic                         in_hint,
	input  logic [COUNT_BITS-1:0]        byte_count,
	output logic                         active_nxt,
	output logic [DEPTH_BITS-1:0]        depth_nxt,
	output logic [COUNT_BITS-1:0]        pending_nxt,
	output logic [COUNT_BITS-1:0]        skip_nxt,
	output logic                         hint_nxt,
	output logic [COUNT_BITS-1:0]        count_nxt,
	output logic [csl_pkg::STATUS_W-1:0] status,
	output logic [csl_pkg::LEN_W-1:0]    total_length
);

	// Wide enough for any compare against the limit or the count ceiling
	localparam int WB = ((COUNT_BITS > csl_pkg::LEN_W) ? COUNT_BITS : csl_pkg::LEN_W) + 2;
	localparam int VW = COUNT_BITS + 4;

	logic                  e_active;
	logic [DEPTH_BITS-1:0] e_depth;
	logic [COUNT_BITS-1:0] e_pend;
	logic [COUNT_BITS-1:0] e_skip;
	logic                  e_hint;
	logic [COUNT_BITS-1:0] e_count;
	logic [COUNT_BITS-1:0] count_inc;
	logic [WB-1:0]         count_w;
	logic [WB-1:0]         pend_w;
	logic [WB-1:0]         max_w;
	logic [WB-1:0]         ceil_w;
	logic [WB-1:0]         len_w;
	logic [VW-1:0]         pend_v;
	logic [VW-1:0]         dec_v;
	logic                  limit_on;
	logic                  is_digit;
	logic                  is_nzdigit;

	// A first byte starts from a clean scan
	always_comb begin
		e_active = active;
		e_depth  = depth;
		e_pend   = pending_length;
		e_skip   = skip_left;
		e_hint   = in_hint;
		e_count  = byte_count;
		if (first) begin
			e_active = 1'b0;
			e_depth  = '0;
			e_pend   = '0;
			e_skip   = '0;
			e_hint   = 1'b0;
			e_count  = '0;
		end
	end

	// Arithmetic on the current byte
	assign count_inc  = e_count + COUNT_BITS'(1);
	assign count_w    = WB'(e_count);
	assign pend_w     = WB'(e_pend);
	assign max_w      = WB'(max_length);
	assign ceil_w     = WB'({COUNT_BITS{1'b1}});
	assign len_w      = WB'(count_inc);
	assign limit_on   = (max_length != '0);
	assign pend_v     = VW'(e_pend);
	assign dec_v      = (pend_v << 3) + (pend_v << 1) + VW'(data_byte[3:0]);
	assign is_digit   = (data_byte >= csl_pkg::CH_ZERO) && (data_byte <= csl_pkg::CH_NINE);
	assign is_nzdigit = (data_byte >= csl_pkg::CH_ONE) && (data_byte <= csl_pkg::CH_NINE);

	// Scan decision and next state
	always_comb begin
		active_nxt   = e_active;
		depth_nxt    = e_depth;
		pending_nxt  = e_pend;
		skip_nxt     = e_skip;
		hint_nxt     = e_hint;
		count_nxt    = e_count;
		status       = csl_pkg::ST_BUSY;
		total_length = '0;

		if (first && (data_byte != csl_pkg::CH_LPAREN)) begin
			status = csl_pkg::ST_ERROR;
		end else if (!first && !e_active) begin
			status = csl_pkg::ST_IDLE;
		end else begin
			active_nxt = 1'b1;
			if (e_skip != '0) begin
				// raw data byte
				skip_nxt  = e_skip - COUNT_BITS'(1);
				count_nxt = count_inc;
			end else if (limit_on && (count_w >= max_w)) begin
				status = csl_pkg::ST_ERROR;
			end else if (&e_count) begin
				status = csl_pkg::ST_ERROR;
			end else if (e_pend != '0) begin
				// inside a length prefix
				if (data_byte == csl_pkg::CH_COLON) begin
					if (limit_on && ((count_w + pend_w) >= max_w)) begin
						status = csl_pkg::ST_ERROR;
					end else if ((len_w + pend_w) > ceil_w) begin
						status = csl_pkg::ST_ERROR;
					end else begin
						skip_nxt    = e_pend;
						pending_nxt = '0;
						count_nxt   = count_inc;
					end
				end else if (is_digit) begin
					if (|dec_v[VW-1:COUNT_BITS]) begin
						status = csl_pkg::ST_ERROR;
					end else begin
						pending_nxt = dec_v[COUNT_BITS-1:0];
						count_nxt   = count_inc;
					end
				end else begin
					status = csl_pkg::ST_ERROR;
				end
			end else if (data_byte == csl_pkg::CH_LPAREN) begin
				if (e_hint || (&e_depth)) begin
					status = csl_pkg::ST_ERROR;
				end else begin
					depth_nxt = e_depth + DEPTH_BITS'(1);
					count_nxt = count_inc;
				end
			end else if (data_byte == csl_pkg::CH_RPAREN) begin
				if ((e_depth == '0) || e_hint) begin
					status = csl_pkg::ST_ERROR;
				end else if (e_depth == DEPTH_BITS'(1)) begin
					status       = csl_pkg::ST_DONE;
					total_length = len_w[csl_pkg::LEN_W-1:0];
				end else begin
					depth_nxt = e_depth - DEPTH_BITS'(1);
					count_nxt = count_inc;
				end
			end else if (data_byte == csl_pkg::CH_LBRACK) begin
				if (e_hint) begin
					status = csl_pkg::ST_ERROR;
				end else begin
					hint_nxt  = 1'b1;
					count_nxt = count_inc;
				end
			end else if (data_byte == csl_pkg::CH_RBRACK) begin
				if (!e_hint) begin
					status = csl_pkg::ST_ERROR;
				end else begin
					hint_nxt  = 1'b0;
					count_nxt = count_inc;
				end
			end else if (is_nzdigit) begin
				pending_nxt = COUNT_BITS'(data_byte[3:0]);
				count_nxt   = count_inc;
			end else begin
				status = csl_pkg::ST_ERROR;
			end
		end

		// scan ends on completion or error
		if ((status == csl_pkg::ST_ERROR) || (status == csl_pkg::ST_DONE)) begin
			active_nxt  = 1'b0;
			depth_nxt   = '0;
			pending_nxt = '0;
			skip_nxt    = '0;
			hint_nxt    = 1'b0;
			count_nxt   = '0;
		end
	end

endmodule

[rtl/core/csl_out_stage.sv]
module csl_out_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [csl_pkg::STATUS_W-1:0] status,
	input  logic [csl_pkg::LEN_W-1:0]    total_length,
	output logic                         can_load,
	csl_out_if.source                    out_ch
);

	logic                         valid_q;
	logic [csl_pkg::STATUS_W-1:0] status_q;
	logic [csl_pkg::LEN_W-1:0]    length_q;

	// Register takes a new result when empty or drained this cycle
	assign can_load = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			status_q <= status;
			length_q <= total_length;
		end
	end

	assign out_ch.valid        = valid_q;
	assign out_ch.status       = status_q;
	assign out_ch.total_length = length_q;

endmodule
